/* rtl/xsa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the xorshift hash function for the xorshift sketch accumulator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package xsa_pkg;

    // Default values for the top-level parameters.
    localparam int TABLE_DEPTH_LOG2_DEF = 19;
    localparam int NUM_HASHES_DEF       = 20;
    localparam int VALUE_WIDTH_DEF      = 32;

    // Fixed field and state widths.
    localparam int SUM_W       = 56;
    localparam int SLOT_W      = 5;
    localparam int MEAN_W      = 32;
    localparam int IP_W        = 32;
    localparam int IDX_W       = 19;
    localparam int TVAL_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int TBL_BITS_W  = 5;
    localparam int HASH_W      = 32;
    localparam int NUM_TRIPLES = 20;

    localparam logic [TBL_BITS_W-1:0] TBL_BITS_MIN = 5'd14;
    localparam logic [TBL_BITS_W-1:0] TBL_BITS_RST = 5'd19;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKETS_PER_WINDOW = 8'd1;

    // Input operation codes.
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_PACKET      = 1'b1;

    // Shift triples (left a, right b, left c), one per hash slot.
    localparam logic [4:0] SHIFT_A [NUM_TRIPLES] = '{
        5'd1, 5'd1, 5'd2, 5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd4, 5'd5,
        5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd14, 5'd14, 5'd1, 5'd1, 5'd11
    };
    localparam logic [4:0] SHIFT_B [NUM_TRIPLES] = '{
        5'd3, 5'd11, 5'd5, 5'd7, 5'd7, 5'd9, 5'd1, 5'd13, 5'd5, 5'd9,
        5'd13, 5'd1, 5'd1, 5'd5, 5'd7, 5'd1, 5'd13, 5'd5, 5'd11, 5'd7
    };
    localparam logic [4:0] SHIFT_C [NUM_TRIPLES] = '{
        5'd10, 5'd6, 5'd15, 5'd7, 5'd9, 5'd15, 5'd14, 5'd7, 5'd15, 5'd7,
        5'd6, 5'd11, 5'd9, 5'd1, 5'd12, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16
    };

    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         table_index;
        logic signed [TVAL_W-1:0] table_value;
        logic [IP_W-1:0]          src_ip;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0]        hash_slot;
        logic signed [MEAN_W-1:0] mean_value;
        logic                     last;
    } t_out_word;

    // Access request to the accumulator memory.
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [SUM_W-1:0]  wr_data;
        logic              clear;
    } t_sum_ctl;

    // Start request to the divider.
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [COUNT_W-1:0]      divisor;
    } t_div_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_MEAN_RD,
        ST_MEAN_LD,
        ST_MEAN_DIV,
        ST_MEAN_OUT
    } t_state;

    function automatic logic [HASH_W-1:0] xs_hash(
        input logic [HASH_W-1:0] x,
        input logic [4:0]        a,
        input logic [4:0]        b,
        input logic [4:0]        c
    );
        logic [HASH_W-1:0] t;
        t = x ^ (x << a);
        t = t ^ (t >> b);
        t = t ^ (t << c);
        return t;
    endfunction

endpackage

/* rtl/xsa_tbl_mem.sv */
`timescale 1ns / 1ps
// Single-port synchronous memory holding the random-value table.
// Depends on xsa_pkg for the default widths; the read data is registered.
module xsa_tbl_mem #(
    parameter int ADDR_W = xsa_pkg::TABLE_DEPTH_LOG2_DEF,
    parameter int DATA_W = xsa_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/xsa_sum_mem.sv */
`timescale 1ns / 1ps
// Accumulator memory: one signed sum per hash slot, with a valid bit per slot.
// Depends on xsa_pkg; a slot whose valid bit is clear reads as zero.
module xsa_sum_mem #(
    parameter int NUM_HASHES = xsa_pkg::NUM_HASHES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  xsa_pkg::t_sum_ctl              i_ctl,
    output logic signed [xsa_pkg::SUM_W-1:0] o_rdata
);

    localparam int AW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

    logic [xsa_pkg::SUM_W-1:0] r_mem [NUM_HASHES];
    logic [NUM_HASHES-1:0]     r_vld;
    logic [xsa_pkg::SUM_W-1:0] r_rdata;
    logic                      r_rd_vld;

    // Valid bits: cleared by reset and at the end of every window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.wr_en) begin
            r_vld[i_ctl.wr_slot[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_slot[AW-1:0]] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata  <= r_mem[i_ctl.rd_slot[AW-1:0]];
            r_rd_vld <= r_vld[i_ctl.rd_slot[AW-1:0]];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

/* rtl/xsa_div.sv */
`timescale 1ns / 1ps
// Restoring divider: signed sum over unsigned count, one quotient bit per cycle.
// Depends on xsa_pkg; the quotient is truncated toward zero.
module xsa_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  xsa_pkg::t_div_req                i_req,
    output logic                             o_busy,
    output logic signed [xsa_pkg::SUM_W:0]   o_quotient
);

    localparam int DIV_STEPS = xsa_pkg::SUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int CW        = xsa_pkg::COUNT_W;

    logic [CNT_W-1:0]              r_cnt;
    logic                          r_neg;
    logic [xsa_pkg::SUM_W-1:0]     r_dvd;
    logic [xsa_pkg::SUM_W-1:0]     r_quo;
    logic [CW-1:0]                 r_rem;
    logic [CW-1:0]                 r_dvs;

    logic [xsa_pkg::SUM_W-1:0]     dvd_mag;
    logic [CW:0]                   shifted;
    logic [CW+1:0]                 diff;
    logic                          q_bit;
    logic [CW-1:0]                 n_rem;
    logic signed [xsa_pkg::SUM_W:0] quo_mag;

    always_comb begin
        // The magnitude of the most negative sum still fits unsigned.
        dvd_mag = i_req.dividend[xsa_pkg::SUM_W-1] ? (~i_req.dividend + 1'b1)
                                                    : i_req.dividend;
        shifted = {r_rem, r_dvd[xsa_pkg::SUM_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        q_bit   = !diff[CW+1];
        n_rem   = q_bit ? diff[CW-1:0] : shifted[CW-1:0];
        quo_mag = {1'b0, r_quo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[xsa_pkg::SUM_W-1];
            r_dvd <= dvd_mag;
            r_quo <= '0;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[xsa_pkg::SUM_W-2:0], 1'b0};
            r_quo <= {r_quo[xsa_pkg::SUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_neg ? -quo_mag : quo_mag;

endmodule

/* rtl/xorshift_sketch_accumulator.sv */
`timescale 1ns / 1ps
// Top level of the xorshift sketch accumulator: control sequencer, hashing and output register.
// Depends on xsa_pkg, xsa_tbl_mem, xsa_sum_mem and xsa_div.
//
// Usage. Input words arrive on i_in_valid / o_in_ready. A word with op at table-write
// stores its value in the random-value table. A word with op at packet
// hashes the source address NUM_HASHES times; each hash, masked to the configured table
// size, reads one table entry through the single table port, and the value is added with
// saturation into that slot's sum, read and written back in the accumulator memory. The
// accumulation is pipelined one slot per cycle, and the next word is accepted only once
// the packet's last sum has been written back and the block is idle again.
// When a packet completes a window, one mean per slot is produced: each takes a memory
// read, a divider load, a division of the sum by the packet count and an output load.
// Means leave on o_out_valid / i_out_ready in slot order, last marking the final one; a
// stalled receiver holds up the sequencer only at the output register, and a new input
// word may be taken while the last mean is still waiting there. Configuration is a
// separate write channel, always ready. Reset clears the sums, the packet count and the
// registers (table size 19, window 1) at once; the table contents are not cleared and
// must be written before use.
module xorshift_sketch_accumulator #(
    parameter int TABLE_DEPTH_LOG2 = xsa_pkg::TABLE_DEPTH_LOG2_DEF,
    parameter int NUM_HASHES       = xsa_pkg::NUM_HASHES_DEF,
    parameter int VALUE_WIDTH      = xsa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  xsa_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output xsa_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [xsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [xsa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SW        = xsa_pkg::SLOT_W;
    localparam int SUMW      = xsa_pkg::SUM_W;
    localparam int IDX_EXT_W = (TABLE_DEPTH_LOG2 > xsa_pkg::IDX_W) ? TABLE_DEPTH_LOG2
                                                                   : xsa_pkg::IDX_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_HASHES - 1);
    localparam logic [xsa_pkg::TBL_BITS_W-1:0] TBL_BITS_MAX =
        xsa_pkg::TBL_BITS_W'(TABLE_DEPTH_LOG2);
    localparam logic [xsa_pkg::TBL_BITS_W-1:0] TBL_BITS_RESET =
        (xsa_pkg::TBL_BITS_RST > TBL_BITS_MAX) ? TBL_BITS_MAX : xsa_pkg::TBL_BITS_RST;
    // Limits of a mean in the signed value range.
    localparam logic signed [SUMW:0] VMAX =
        (SUMW + 1)'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUMW:0] VMIN =
        (SUMW + 1)'(-(64'sd1 <<< (VALUE_WIDTH - 1)));

    // Control state.
    xsa_pkg::t_state                   r_state, n_state;
    logic [SW-1:0]                     r_slot, n_slot;
    logic [xsa_pkg::COUNT_W-1:0]       r_seen, n_seen;
    logic                              r_emit;
    logic                              r_wb_vld;
    logic [xsa_pkg::TBL_BITS_W-1:0]    r_tbl_bits, n_tbl_bits;
    logic [xsa_pkg::COUNT_W-1:0]       r_window, n_window;
    logic                              r_out_valid;

    // Payload registers.
    logic [xsa_pkg::IP_W-1:0]          r_ip;
    logic [SW-1:0]                     r_wb_slot;
    xsa_pkg::t_out_word                r_out_word;

    // Combinational signals.
    logic                              in_fire;
    logic                              pkt_fire;
    logic                              last_slot;
    logic                              out_free;
    logic                              out_load;
    logic                              slot_step;
    logic                              tbl_we;
    logic [TABLE_DEPTH_LOG2-1:0]       tbl_addr;
    logic [TABLE_DEPTH_LOG2-1:0]       hash_addr;
    logic [TABLE_DEPTH_LOG2-1:0]       tbl_mask;
    logic [IDX_EXT_W-1:0]              idx_ext;
    logic [63:0]                       tval_ext;
    logic [VALUE_WIDTH-1:0]            tbl_wdata;
    logic [VALUE_WIDTH-1:0]            tbl_rdata;
    logic [xsa_pkg::HASH_W-1:0]        hash;
    logic signed [SUMW-1:0]            sum_rdata;
    logic signed [SUMW:0]              acc_sum;
    logic [SUMW-1:0]                   sat_sum;
    xsa_pkg::t_sum_ctl                 sum_ctl;
    xsa_pkg::t_div_req                 div_req;
    logic                              div_busy;
    logic signed [SUMW:0]              div_quot;
    logic signed [SUMW:0]              mean_clamped;

    assign in_fire   = i_in_valid && o_in_ready;
    assign pkt_fire  = in_fire && (i_in_word.op == xsa_pkg::OP_PACKET);
    assign last_slot = (r_slot == LAST_SLOT);
    assign out_free  = !r_out_valid || i_out_ready;

    // Hash address for the current slot, masked to the configured table size.
    always_comb begin
        hash = xsa_pkg::xs_hash(r_ip, xsa_pkg::SHIFT_A[r_slot], xsa_pkg::SHIFT_B[r_slot],
                                xsa_pkg::SHIFT_C[r_slot]);
        for (int i = 0; i < TABLE_DEPTH_LOG2; i++) begin
            tbl_mask[i] = (i < int'(r_tbl_bits));
        end
        hash_addr = hash[TABLE_DEPTH_LOG2-1:0] & tbl_mask;
    end

    // Table write path: index masked to the table depth, value sign-extended and wrapped.
    always_comb begin
        idx_ext   = IDX_EXT_W'(i_in_word.table_index);
        tval_ext  = {{32{i_in_word.table_value[xsa_pkg::TVAL_W-1]}}, i_in_word.table_value};
        tbl_wdata = tval_ext[VALUE_WIDTH-1:0];
    end

    // Saturating accumulation of the table value into the slot's sum.
    always_comb begin
        acc_sum = {sum_rdata[SUMW-1], sum_rdata}
                + {{(SUMW + 1 - VALUE_WIDTH){tbl_rdata[VALUE_WIDTH-1]}}, tbl_rdata};
        if (acc_sum[SUMW] != acc_sum[SUMW-1]) begin
            sat_sum = acc_sum[SUMW] ? {1'b1, {(SUMW - 1){1'b0}}}
                                    : {1'b0, {(SUMW - 1){1'b1}}};
        end else begin
            sat_sum = acc_sum[SUMW-1:0];
        end
    end

    // Mean clamped to the signed value range.
    always_comb begin
        if (div_quot > VMAX) begin
            mean_clamped = VMAX;
        end else if (div_quot < VMIN) begin
            mean_clamped = VMIN;
        end else begin
            mean_clamped = div_quot;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xsa_pkg::ST_IDLE: begin
                if (pkt_fire) begin
                    n_state = xsa_pkg::ST_ACC;
                end
            end
            xsa_pkg::ST_ACC: begin
                if (last_slot) begin
                    n_state = xsa_pkg::ST_DRAIN;
                end
            end
            xsa_pkg::ST_DRAIN: begin
                n_state = r_emit ? xsa_pkg::ST_MEAN_RD : xsa_pkg::ST_IDLE;
            end
            xsa_pkg::ST_MEAN_RD: begin
                n_state = xsa_pkg::ST_MEAN_LD;
            end
            xsa_pkg::ST_MEAN_LD: begin
                n_state = xsa_pkg::ST_MEAN_DIV;
            end
            xsa_pkg::ST_MEAN_DIV: begin
                if (!div_busy) begin
                    n_state = xsa_pkg::ST_MEAN_OUT;
                end
            end
            xsa_pkg::ST_MEAN_OUT: begin
                if (out_free) begin
                    n_state = last_slot ? xsa_pkg::ST_IDLE : xsa_pkg::ST_MEAN_RD;
                end
            end
            default: begin
                n_state = xsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_ready = (r_state == xsa_pkg::ST_IDLE);
        tbl_we     = in_fire && (i_in_word.op == xsa_pkg::OP_TABLE_WRITE);
        tbl_addr   = (r_state == xsa_pkg::ST_IDLE) ? idx_ext[TABLE_DEPTH_LOG2-1:0] : hash_addr;
        out_load   = (r_state == xsa_pkg::ST_MEAN_OUT) && out_free;
        slot_step  = (r_state == xsa_pkg::ST_ACC) || out_load;

        // The slot being written back always trails the slot being read by one.
        sum_ctl.rd_en   = (r_state == xsa_pkg::ST_ACC) || (r_state == xsa_pkg::ST_MEAN_RD);
        sum_ctl.rd_slot = r_slot;
        sum_ctl.wr_en   = r_wb_vld;
        sum_ctl.wr_slot = r_wb_slot;
        sum_ctl.wr_data = sat_sum;
        sum_ctl.clear   = out_load && last_slot;

        div_req.start    = (r_state == xsa_pkg::ST_MEAN_LD);
        div_req.dividend = sum_rdata;
        div_req.divisor  = r_seen;
    end

    // Next values of counters and configuration.
    always_comb begin
        n_slot = r_slot;
        if (slot_step) begin
            n_slot = last_slot ? '0 : r_slot + SW'(1);
        end

        n_seen = r_seen;
        if (pkt_fire) begin
            n_seen = r_seen + 1'b1;
        end else if (sum_ctl.clear) begin
            n_seen = '0;
        end

        n_tbl_bits = r_tbl_bits;
        n_window   = r_window;
        if (i_cfg_valid) begin
            if (i_cfg_index == xsa_pkg::CFG_TABLE_SIZE_LOG2) begin
                n_tbl_bits = i_cfg_data[xsa_pkg::TBL_BITS_W-1:0];
                if (n_tbl_bits < xsa_pkg::TBL_BITS_MIN) begin
                    n_tbl_bits = xsa_pkg::TBL_BITS_MIN;
                end else if (n_tbl_bits > TBL_BITS_MAX) begin
                    n_tbl_bits = TBL_BITS_MAX;
                end
            end else if (i_cfg_index == xsa_pkg::CFG_PACKETS_PER_WINDOW) begin
                // A window of zero behaves as a window of one.
                n_window = (i_cfg_data == '0) ? xsa_pkg::COUNT_W'(1) : i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xsa_pkg::ST_IDLE;
            r_slot      <= '0;
            r_seen      <= '0;
            r_emit      <= 1'b0;
            r_wb_vld    <= 1'b0;
            r_tbl_bits  <= TBL_BITS_RESET;
            r_window    <= xsa_pkg::COUNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_seen     <= n_seen;
            r_wb_vld   <= (r_state == xsa_pkg::ST_ACC);
            r_tbl_bits <= n_tbl_bits;
            r_window   <= n_window;
            if (pkt_fire) begin
                // A window closes once the count reaches the window, even if it was lowered.
                r_emit <= (n_seen >= r_window);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pkt_fire) begin
            r_ip <= i_in_word.src_ip;
        end
        r_wb_slot <= r_slot;
        if (out_load) begin
            r_out_word.hash_slot  <= r_slot;
            r_out_word.mean_value <= mean_clamped[xsa_pkg::MEAN_W-1:0];
            r_out_word.last       <= last_slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    xsa_tbl_mem #(
        .ADDR_W (TABLE_DEPTH_LOG2),
        .DATA_W (VALUE_WIDTH)
    ) u_tbl_mem (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_addr  (tbl_addr),
        .i_wdata (tbl_wdata),
        .o_rdata (tbl_rdata)
    );

    xsa_sum_mem #(
        .NUM_HASHES (NUM_HASHES)
    ) u_sum_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sum_ctl),
        .o_rdata (sum_rdata)
    );

    xsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_busy     (div_busy),
        .o_quotient (div_quot)
    );

    // The read-modify-write pipeline never reads and writes the same slot in one cycle.
    a_no_sum_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sum_ctl.rd_en && sum_ctl.wr_en) |-> (sum_ctl.rd_slot != sum_ctl.wr_slot))
        else $error("accumulator read and write hit the same slot");

    // A division is only started when the divider is free.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    // Write-backs only happen while a packet is being accumulated.
    a_wb_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_ctl.wr_en |-> (r_state == xsa_pkg::ST_ACC || r_state == xsa_pkg::ST_DRAIN))
        else $error("accumulator written outside a packet");

    // The final mean of a window carries the last slot number.
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last) |-> (o_out_word.hash_slot == LAST_SLOT))
        else $error("last flag on a slot other than the final one");

    // Closing a window restarts the packet count.
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_ctl.clear |=> (r_seen == '0))
        else $error("packet count not cleared at the end of a window");

endmodule

/* sim/tb_xorshift_sketch_accumulator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for xorshift_sketch_accumulator: table writes and packet words
// are queued, driven with random gaps, and the emitted means are checked against a predictor.
// Depends on xsa_pkg and the RTL under rtl/.
module tb_xorshift_sketch_accumulator;
    import xsa_pkg::*;

    localparam int SLOTS        = NUM_HASHES_DEF;
    localparam int DEPTH_BITS   = TABLE_DEPTH_LOG2_DEF;
    localparam int QUIET_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int WORD_TARGET  = 230;

    localparam longint SUM_HI  = 64'sh007F_FFFF_FFFF_FFFF;
    localparam longint SUM_LO  = -SUM_HI - 64'sd1;
    localparam longint MEAN_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint MEAN_LO = -MEAN_HI - 64'sd1;

    // Shift triples of the twenty hashes: left, right, left.
    localparam int MIX_A [SLOTS] = '{1, 1, 2, 2, 2, 2, 3, 3, 4, 5,
                                     5, 6, 7, 9, 11, 14, 14, 1, 1, 11};
    localparam int MIX_B [SLOTS] = '{3, 11, 5, 7, 7, 9, 1, 13, 5, 9,
                                     13, 1, 1, 5, 7, 1, 13, 5, 11, 7};
    localparam int MIX_C [SLOTS] = '{10, 6, 15, 7, 9, 15, 14, 7, 15, 7,
                                     6, 11, 9, 1, 12, 15, 15, 16, 16, 16};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Copies of the register values as written, unclamped; only changed while the block is idle.
    logic [TBL_BITS_W-1:0] cfg_table_bits = TBL_BITS_RST;
    logic [31:0]           cfg_window = 32'd1;

    // Predictor state: the value table, the twenty running sums and the window count.
    bit signed [31:0]      sketch_values [0:(1 << DEPTH_BITS) - 1];
    longint                acc_sums [SLOTS];
    longint                packets_in_window = 0;
    t_out_word             expected_means [$];

    // Stimulus side: words still to be driven, which table entries have been loaded,
    // and the addresses already sent so that packets can repeat them.
    t_in_word              word_backlog [$];
    bit                    entry_loaded [0:(1 << DEPTH_BITS) - 1];
    logic [31:0]           ip_pool [$];
    int                    words_queued = 0;

    int                    gap_left = 0;
    int                    stall_left = 0;
    int                    tx_calm = 0;
    int                    rx_calm = 0;
    int                    mismatches = 0;
    int                    cycle_count = 0;
    t_out_word             mean_due;

    xorshift_sketch_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // One xorshift hash of a 32-bit address with the triple of slot k.
    function automatic logic [31:0] xorshift_mix(input logic [31:0] ip, input int k);
        logic [31:0] t;
        t = ip ^ (ip << MIX_A[k]);
        t = t ^ (t >> MIX_B[k]);
        return t ^ (t << MIX_C[k]);
    endfunction

    // The configured table size is clamped to the range the hardware supports.
    function automatic logic [31:0] live_index_mask();
        int bits;
        bits = int'(cfg_table_bits);
        if (bits < int'(TBL_BITS_MIN))
            bits = int'(TBL_BITS_MIN);
        if (bits > DEPTH_BITS)
            bits = DEPTH_BITS;
        return (32'd1 << bits) - 32'd1;
    endfunction

    // Wait drawn per word on either side; now and then a calm stretch with no waits at all.
    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Table values lean towards the signed extremes, so that sums and means reach them.
    function automatic logic [31:0] draw_table_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Applies one accepted word to the predictor. A packet that fills the window queues
    // twenty means, each sum divided by the packet count and truncated towards zero.
    function automatic void absorb_word(input t_in_word w);
        logic [31:0] idx;
        longint      s;
        longint      m;
        longint      win;
        t_out_word   e;
        if (w.op == OP_TABLE_WRITE) begin
            sketch_values[w.table_index] = w.table_value;
            return;
        end
        for (int k = 0; k < SLOTS; k++) begin
            idx = xorshift_mix(w.src_ip, k) & live_index_mask();
            s = acc_sums[k] + longint'(sketch_values[idx[DEPTH_BITS-1:0]]);
            if (s > SUM_HI)
                s = SUM_HI;
            if (s < SUM_LO)
                s = SUM_LO;
            acc_sums[k] = s;
        end
        packets_in_window++;
        // A zero window behaves as a window of one; a window lowered below the count
        // already reached closes on the next packet, dividing by the full count.
        win = (cfg_window == 32'd0) ? 64'sd1 : longint'({32'd0, cfg_window});
        if (packets_in_window < win)
            return;
        for (int k = 0; k < SLOTS; k++) begin
            m = acc_sums[k] / packets_in_window;
            if (m > MEAN_HI)
                m = MEAN_HI;
            if (m < MEAN_LO)
                m = MEAN_LO;
            e.hash_slot  = k[SLOT_W-1:0];
            e.mean_value = m[MEAN_W-1:0];
            e.last       = (k == SLOTS - 1);
            expected_means.push_back(e);
            acc_sums[k] = 0;
        end
        packets_in_window = 0;
    endfunction

    function automatic void queue_table_write(input logic [31:0] idx, input logic [31:0] val);
        t_in_word w;
        w.op          = OP_TABLE_WRITE;
        w.table_index = idx[IDX_W-1:0];
        w.table_value = val;
        w.src_ip      = $urandom;
        entry_loaded[idx[IDX_W-1:0]] = 1'b1;
        word_backlog.push_back(w);
        words_queued++;
    endfunction

    // A packet is preceded by writes of every entry its hashes reach that has never been
    // loaded, since the table holds nothing defined until written.
    function automatic void queue_packet(input logic [31:0] ip);
        logic [31:0] idx;
        t_in_word    w;
        for (int k = 0; k < SLOTS; k++) begin
            idx = xorshift_mix(ip, k) & live_index_mask();
            if (!entry_loaded[idx[DEPTH_BITS-1:0]])
                queue_table_write(idx, draw_table_value());
        end
        w.op          = OP_PACKET;
        w.table_index = IDX_W'($urandom);
        w.table_value = $urandom;
        w.src_ip      = ip;
        word_backlog.push_back(w);
        words_queued++;
        ip_pool.push_back(ip);
    endfunction

    // Mostly packets that repeat known addresses, so that windows fill often; the rest are
    // stray table writes and, rarely, fresh addresses, a few of them at the extremes. A
    // fresh address costs up to twenty table writes, so they are kept scarce.
    function automatic void random_phase(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                queue_table_write($urandom, draw_table_value());
            end else if (r < 92 && ip_pool.size() > 0) begin
                queue_packet(ip_pool[$urandom_range(0, ip_pool.size() - 1)]);
            end else if (r < 95) begin
                case ($urandom_range(0, 3))
                    0:       queue_packet(32'h0000_0000);
                    1:       queue_packet(32'hFFFF_FFFF);
                    2:       queue_packet(32'h8000_0000);
                    default: queue_packet(32'h0000_0001);
                endcase
            end else begin
                queue_packet($urandom);
            end
        end
    endfunction

    // Holds the test sequence back until the backlog is drained and every mean has arrived, then
    // gives a packet that produced no mean time to leave the pipeline.
    task automatic settle();
        @(negedge i_clk);
        while (word_backlog.size() != 0 || i_in_valid || expected_means.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        // Indexes other than the two registers are ignored by the block.
        if (idx == CFG_TABLE_SIZE_LOG2)
            cfg_table_bits = data[TBL_BITS_W-1:0];
        else if (idx == CFG_PACKETS_PER_WINDOW)
            cfg_window = data;
        @(negedge i_clk);
    endtask

    // Sender: a word stays on the bus until taken; the wait before the next word is drawn
    // when the current one is put up, and is served once the bus is free again.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                absorb_word(i_in_word);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (word_backlog.size() > 0) begin
                    i_in_word  <= word_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    gap_left   <= draw_pause(tx_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: after each mean it holds ready low for a drawn number of cycles, and every
    // mean taken is compared field by field with the oldest one predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_means.size() == 0) begin
                    mismatches++;
                    $display("%0t: mean with none predicted: slot %0d value %0d last %0b",
                             $time, o_out_word.hash_slot, o_out_word.mean_value,
                             o_out_word.last);
                end else begin
                    mean_due = expected_means.pop_front();
                    if (o_out_word.hash_slot !== mean_due.hash_slot
                            || o_out_word.mean_value !== mean_due.mean_value
                            || o_out_word.last !== mean_due.last) begin
                        mismatches++;
                        $display("%0t: expected %0d/%0d/%0b, got %0d/%0d/%0b (slot/value/last)",
                                 $time, mean_due.hash_slot, mean_due.mean_value,
                                 mean_due.last, o_out_word.hash_slot,
                                 o_out_word.mean_value, o_out_word.last);
                    end
                end
                stall_left = draw_pause(rx_calm);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_xorshift_sketch_accumulator NOT OK");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < SLOTS; k++)
            acc_sums[k] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: full table, window of one. Every hash of a zero address is zero,
        // so the means equal the value at entry zero: first the largest, then the smallest.
        queue_table_write(32'h0007_FFFF, 32'hFFFF_FFFF);
        queue_table_write(32'h0000_0000, 32'h7FFF_FFFF);
        queue_packet(32'h0000_0000);
        queue_table_write(32'h0000_0000, 32'h8000_0000);
        queue_packet(32'h0000_0000);
        queue_packet(32'hFFFF_FFFF);

        // Smallest table and a window of two.
        settle();
        write_register(CFG_TABLE_SIZE_LOG2, 32'd14);
        write_register(CFG_PACKETS_PER_WINDOW, 32'd2);
        random_phase(12);

        // A table size below the range acts as the smallest, a zero window as one.
        settle();
        write_register(CFG_TABLE_SIZE_LOG2, 32'd0);
        write_register(CFG_PACKETS_PER_WINDOW, 32'd0);
        random_phase(10);

        // A table size above the range acts as the largest. Two packets of a window of
        // three, then the window is lowered to one: the next packet closes it, and the
        // sums are divided by the full count.
        settle();
        write_register(CFG_TABLE_SIZE_LOG2, 32'd31);
        write_register(CFG_PACKETS_PER_WINDOW, 32'd3);
        queue_packet($urandom);
        queue_packet(ip_pool[$urandom_range(0, ip_pool.size() - 1)]);
        settle();
        write_register(CFG_PACKETS_PER_WINDOW, 32'd1);
        queue_packet(ip_pool[$urandom_range(0, ip_pool.size() - 1)]);
        random_phase(8);

        // Writes to unknown indexes must change nothing. The largest window never closes,
        // and lowering it afterwards flushes everything gathered meanwhile.
        settle();
        write_register(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
        write_register(8'd255, $urandom);
        write_register(CFG_TABLE_SIZE_LOG2, 32'd17);
        write_register(CFG_PACKETS_PER_WINDOW, 32'hFFFF_FFFF);
        random_phase(6);
        settle();
        write_register(CFG_TABLE_SIZE_LOG2, 32'd19);
        write_register(CFG_PACKETS_PER_WINDOW, 32'd4);
        random_phase(8);

        // Random settings from here on, mostly small windows so that means keep coming.
        while (words_queued < WORD_TARGET) begin
            settle();
            if ($urandom_range(0, 4) == 0)
                write_register(CFG_TABLE_SIZE_LOG2, $urandom_range(0, 31));
            else
                write_register(CFG_TABLE_SIZE_LOG2, $urandom_range(14, 19));
            case ($urandom_range(0, 7))
                0:       write_register(CFG_PACKETS_PER_WINDOW, 32'd0);
                6:       write_register(CFG_PACKETS_PER_WINDOW, $urandom_range(4, 6));
                7:       write_register(CFG_PACKETS_PER_WINDOW, 32'd1);
                default: write_register(CFG_PACKETS_PER_WINDOW, $urandom_range(1, 3));
            endcase
            random_phase($urandom_range(4, 10));
        end

        settle();
        if (mismatches == 0)
            $display("tb_xorshift_sketch_accumulator OK");
        else
            $display("tb_xorshift_sketch_accumulator NOT OK");
        $finish;
    end
endmodule

/* filelist.f */
rtl/xsa_pkg.sv
rtl/xsa_tbl_mem.sv
rtl/xsa_sum_mem.sv
rtl/xsa_div.sv
rtl/xorshift_sketch_accumulator.sv
sim/tb_xorshift_sketch_accumulator.sv
